// ===== design/set_assoc_lru_cache_tracker_assert.svh =====
// assertion macros for the set-associative lru cache tracker
`ifndef SET_ASSOC_LRU_CACHE_TRACKER_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_TRACKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SACTK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SACTK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sactk_pkg.sv =====
// shared constants and types for the set-associative lru cache tracker
package sactk_pkg;

    // fixed field widths
    localparam int ADDR_W     = 64;
    localparam int ACTION_W   = 2;
    localparam int TOTAL_W    = 32;
    localparam int SET_BITS_W = 3;
    localparam int BLK_BITS_W = 5;
    localparam int WAYS_CFG_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int SHIFT_W    = 6;

    // parameter defaults
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_AGE_WIDTH    = 32;

    // depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // access kinds
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_STORE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MODIFY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    // configuration reset values
    localparam logic [SET_BITS_W-1:0] RST_SET_BITS = 3'd1;
    localparam logic [BLK_BITS_W-1:0] RST_BLK_BITS = 5'd1;
    localparam logic [WAYS_CFG_W-1:0] RST_WAYS     = 4'd1;

    // configuration register set
    typedef struct packed {
        logic [SET_BITS_W-1:0] set_bits;
        logic [BLK_BITS_W-1:0] blk_bits;
        logic [WAYS_CFG_W-1:0] ways;
    } t_cfg;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_UPDATE
    } t_back_state;

endpackage

// ===== design/sactk_front.sv =====
// front end: configuration registers, address split and request push
module sactk_front #(
    parameter int MAX_SET_BITS = sactk_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sactk_pkg::DEF_MAX_WAYS,
    parameter int REQ_W        = sactk_pkg::ADDR_W + MAX_SET_BITS
                                 + $clog2(MAX_WAYS + 1) + 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic [sactk_pkg::ACTION_W-1:0]   i_action,
    input  logic [sactk_pkg::ADDR_W-1:0]     i_address,
    output logic                             busy,
    input  logic                             i_cfg_valid,
    input  logic [sactk_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sactk_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                             o_cfg_ready,
    input  logic                             i_q_full,
    input  logic                             i_clearing,
    output logic                             o_push,
    output logic [REQ_W-1:0]                 o_req
);
    import sactk_pkg::*;

    localparam int SET_W   = MAX_SET_BITS;
    localparam int SB_W    = $clog2(MAX_SET_BITS + 1);
    localparam int WAYS_CW = $clog2(MAX_WAYS + 1);

    t_cfg r_cfg;

    logic [SB_W-1:0]    eff_sbits;
    logic [SET_W:0]     set_span;
    logic [SET_W-1:0]   set_mask;
    logic [ADDR_W-1:0]  blk_shifted;
    logic [SET_W-1:0]   set_idx;
    logic [SHIFT_W-1:0] tag_shift;
    logic [ADDR_W-1:0]  tag;
    logic [WAYS_CW-1:0] eff_ways;
    logic               is_modify;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits <= RST_SET_BITS;
            r_cfg.blk_bits <= RST_BLK_BITS;
            r_cfg.ways     <= RST_WAYS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SET_BITS:   r_cfg.set_bits <= i_cfg_data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: r_cfg.blk_bits <= i_cfg_data[BLK_BITS_W-1:0];
                CFG_WAYS:       r_cfg.ways     <= i_cfg_data[WAYS_CFG_W-1:0];
                default:        r_cfg          <= r_cfg;
            endcase
        end
    end

    // clamp configuration and split the address into set and tag
    always_comb begin
        if (int'(r_cfg.set_bits) > MAX_SET_BITS) begin
            eff_sbits = SB_W'(MAX_SET_BITS);
        end else begin
            eff_sbits = SB_W'(r_cfg.set_bits);
        end
        set_span    = (SET_W + 1)'(1) << eff_sbits;
        set_mask    = SET_W'(set_span - (SET_W + 1)'(1));
        blk_shifted = i_address >> r_cfg.blk_bits;
        set_idx     = blk_shifted[SET_W-1:0] & set_mask;
        tag_shift   = SHIFT_W'(r_cfg.blk_bits) + SHIFT_W'(eff_sbits);
        tag         = i_address >> tag_shift;
        if (r_cfg.ways == '0) begin
            eff_ways = WAYS_CW'(1);
        end else if (int'(r_cfg.ways) > MAX_WAYS) begin
            eff_ways = WAYS_CW'(MAX_WAYS);
        end else begin
            eff_ways = WAYS_CW'(r_cfg.ways);
        end
        is_modify = (i_action == ACT_MODIFY);
    end

    // accept while the queue has room and the store is not being cleared
    assign busy   = i_clearing || i_q_full;
    assign o_push = start && !busy;
    assign o_req  = {is_modify, eff_ways, set_idx, tag};

endmodule

// ===== design/sactk_queue.sv =====
// small request queue between front and back
module sactk_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/sactk_back.sv =====
// back end: set store, lru update, victim choice and running totals
module sactk_back #(
    parameter int MAX_SET_BITS = sactk_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sactk_pkg::DEF_MAX_WAYS,
    parameter int AGE_WIDTH    = sactk_pkg::DEF_AGE_WIDTH,
    parameter int REQ_W        = sactk_pkg::ADDR_W + MAX_SET_BITS
                                 + $clog2(MAX_WAYS + 1) + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  logic [REQ_W-1:0]              i_q_data,
    output logic                          o_q_pop,
    output logic                          o_clearing,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic                          o_miss,
    output logic                          o_eviction,
    output logic                          o_extra_hit,
    output logic [sactk_pkg::TOTAL_W-1:0] o_total_hits,
    output logic [sactk_pkg::TOTAL_W-1:0] o_total_misses,
    output logic [sactk_pkg::TOTAL_W-1:0] o_total_evictions
);
    import sactk_pkg::*;

    localparam int SET_W     = MAX_SET_BITS;
    localparam int SET_COUNT = 1 << MAX_SET_BITS;
    localparam int WAYS_CW   = $clog2(MAX_WAYS + 1);
    localparam int WAY_IW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TREE_LVLS = $clog2(MAX_WAYS);
    localparam int TREE_N    = 1 << TREE_LVLS;
    localparam int TAG_OFF   = MAX_WAYS;
    localparam int AGE_OFF   = MAX_WAYS * (1 + ADDR_W);
    localparam int ROW_W     = MAX_WAYS * (1 + ADDR_W + AGE_WIDTH);
    localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

    // set store: one row holds valid bits, tags and ages of every way
    logic [ROW_W-1:0] mem [SET_COUNT];

    t_back_state r_state;
    t_back_state n_state;

    logic [SET_W-1:0] r_clr_idx;
    logic [ROW_W-1:0] r_row;
    logic [REQ_W-1:0] r_req;

    logic             rd_en;
    logic [SET_W-1:0] rd_addr;
    logic             wr_en;
    logic [SET_W-1:0] wr_addr;
    logic [ROW_W-1:0] wr_row;
    logic             upd;

    logic [ADDR_W-1:0]  req_tag;
    logic [SET_W-1:0]   req_set;
    logic [WAYS_CW-1:0] req_ways;
    logic               req_modify;

    logic                 row_valid [MAX_WAYS];
    logic [ADDR_W-1:0]    row_tag   [MAX_WAYS];
    logic [AGE_WIDTH-1:0] row_age   [MAX_WAYS];
    logic                 in_use    [MAX_WAYS];
    logic                 match     [MAX_WAYS];
    logic [AGE_WIDTH-1:0] aged      [MAX_WAYS];

    logic                 node_en  [TREE_LVLS+1][TREE_N];
    logic [AGE_WIDTH-1:0] node_age [TREE_LVLS+1][TREE_N];
    logic [WAY_IW-1:0]    node_idx [TREE_LVLS+1][TREE_N];

    logic              any_hit;
    logic              any_free;
    logic [WAY_IW-1:0] free_idx;
    logic [WAY_IW-1:0] victim;
    logic              do_miss;
    logic              do_evict;
    logic [ROW_W-1:0]  new_row;

    logic [1:0]         hit_add;
    logic [TOTAL_W:0]   hit_sum;
    logic [TOTAL_W-1:0] n_hits;
    logic [TOTAL_W-1:0] n_misses;
    logic [TOTAL_W-1:0] n_evictions;

    logic [TOTAL_W-1:0] r_hits;
    logic [TOTAL_W-1:0] r_misses;
    logic [TOTAL_W-1:0] r_evictions;
    logic               r_valid;
    logic               r_hit;
    logic               r_miss;
    logic               r_evict;
    logic               r_extra;

    assign req_tag    = r_req[ADDR_W-1:0];
    assign req_set    = r_req[ADDR_W +: SET_W];
    assign req_ways   = r_req[ADDR_W + SET_W +: WAYS_CW];
    assign req_modify = r_req[REQ_W-1];
    assign rd_addr    = i_q_data[ADDR_W +: SET_W];
    assign upd        = (r_state == BK_UPDATE);
    assign o_clearing = (r_state == BK_CLEAR);

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, queue pop and store access
    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = req_set;
        wr_row  = new_row;
        case (r_state)
            BK_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_idx;
                wr_row  = '0;
                if (r_clr_idx == SET_W'(SET_COUNT - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    rd_en   = 1'b1;
                    n_state = BK_UPDATE;
                end
            end
            BK_UPDATE: begin
                wr_en   = 1'b1;
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_CLEAR;
            end
        endcase
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (r_state == BK_CLEAR) begin
            r_clr_idx <= r_clr_idx + SET_W'(1);
        end
    end

    // set store with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            r_row <= mem[rd_addr];
        end
    end

    // request held for the update cycle
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_req <= i_q_data;
        end
    end

    // per-way tag compare and aging
    always_comb begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        free_idx = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            row_valid[w] = r_row[w];
            row_tag[w]   = r_row[TAG_OFF + w * ADDR_W +: ADDR_W];
            row_age[w]   = r_row[AGE_OFF + w * AGE_WIDTH +: AGE_WIDTH];
            in_use[w]    = (WAYS_CW'(w) < req_ways);
            match[w]     = in_use[w] && row_valid[w] && (row_tag[w] == req_tag);
            if (match[w]) begin
                aged[w] = '0;
            end else if (row_age[w] == AGE_MAX) begin
                aged[w] = AGE_MAX;
            end else begin
                aged[w] = row_age[w] + AGE_WIDTH'(1);
            end
            any_hit = any_hit | match[w];
            // last free way wins
            if (in_use[w] && !row_valid[w]) begin
                any_free = 1'b1;
                free_idx = WAY_IW'(w);
            end
        end
    end

    // oldest way: compare tree that keeps the lower way on a tie
    always_comb begin
        for (int l = 0; l <= TREE_LVLS; l++) begin
            for (int i = 0; i < TREE_N; i++) begin
                node_en[l][i]  = 1'b0;
                node_age[l][i] = '0;
                node_idx[l][i] = '0;
            end
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            node_en[0][i]  = in_use[i];
            node_age[0][i] = aged[i];
            node_idx[0][i] = WAY_IW'(i);
        end
        for (int l = 0; l < TREE_LVLS; l++) begin
            for (int i = 0; i < TREE_N / 2; i++) begin
                if (!node_en[l][2*i] ||
                    (node_en[l][2*i+1] && (node_age[l][2*i+1] > node_age[l][2*i]))) begin
                    node_en[l+1][i]  = node_en[l][2*i+1];
                    node_age[l+1][i] = node_age[l][2*i+1];
                    node_idx[l+1][i] = node_idx[l][2*i+1];
                end else begin
                    node_en[l+1][i]  = node_en[l][2*i];
                    node_age[l+1][i] = node_age[l][2*i];
                    node_idx[l+1][i] = node_idx[l][2*i];
                end
            end
        end
    end

    // victim, fill and updated row
    always_comb begin
        victim   = any_free ? free_idx : node_idx[TREE_LVLS][0];
        do_miss  = !any_hit;
        do_evict = do_miss && !any_free;
        new_row  = r_row;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (in_use[w]) begin
                new_row[AGE_OFF + w * AGE_WIDTH +: AGE_WIDTH] = aged[w];
                if (do_miss && (victim == WAY_IW'(w))) begin
                    new_row[w]                                    = 1'b1;
                    new_row[TAG_OFF + w * ADDR_W +: ADDR_W]       = req_tag;
                    new_row[AGE_OFF + w * AGE_WIDTH +: AGE_WIDTH] = '0;
                end
            end
        end
    end

    // saturating totals
    always_comb begin
        hit_add = {1'b0, any_hit} + {1'b0, req_modify};
        hit_sum = {1'b0, r_hits} + (TOTAL_W + 1)'(hit_add);
        n_hits  = hit_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : hit_sum[TOTAL_W-1:0];
        if (do_miss && (r_misses != {TOTAL_W{1'b1}})) begin
            n_misses = r_misses + TOTAL_W'(1);
        end else begin
            n_misses = r_misses;
        end
        if (do_evict && (r_evictions != {TOTAL_W{1'b1}})) begin
            n_evictions = r_evictions + TOTAL_W'(1);
        end else begin
            n_evictions = r_evictions;
        end
    end

    // result strobe and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evictions <= '0;
        end else begin
            r_valid <= upd;
            if (upd) begin
                r_hits      <= n_hits;
                r_misses    <= n_misses;
                r_evictions <= n_evictions;
            end
        end
    end

    // result flags
    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_hit   <= any_hit;
            r_miss  <= do_miss;
            r_evict <= do_evict;
            r_extra <= req_modify;
        end
    end

    assign o_valid           = r_valid;
    assign o_hit             = r_hit;
    assign o_miss            = r_miss;
    assign o_eviction        = r_evict;
    assign o_extra_hit       = r_extra;
    assign o_total_hits      = r_hits;
    assign o_total_misses    = r_misses;
    assign o_total_evictions = r_evictions;

endmodule

// ===== design/set_assoc_lru_cache_tracker.sv =====
// top level of the set-associative lru cache tracker
//
//   channel   direction  handshake                        beat
//   access    in         start high, busy low             i_action, i_address
//   result    out        o_valid strobe, one cycle        flags and running totals
//   config    in         i_cfg_valid and o_cfg_ready      i_cfg_index, i_cfg_data
//
// the back end handles one access at a time: in the idle state it pops the access
// and reads the set row, in the update state it updates ages, fills the victim and
// writes the row back; the result strobe is registered from the update state.
// after reset the store is swept, one set per cycle, over all 2**MAX_SET_BITS
// sets with busy high; config writes are taken throughout.
// busy also rises while the two-entry request queue is full.
// the result side cannot stall: each result is shown for exactly one cycle.
module set_assoc_lru_cache_tracker #(
    parameter int MAX_SET_BITS = sactk_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = sactk_pkg::DEF_MAX_WAYS,
    parameter int AGE_WIDTH    = sactk_pkg::DEF_AGE_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic [sactk_pkg::ACTION_W-1:0]   i_action,
    input  logic [sactk_pkg::ADDR_W-1:0]     i_address,
    output logic                             busy,
    input  logic                             i_cfg_valid,
    input  logic [sactk_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sactk_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                             o_cfg_ready,
    output logic                             o_valid,
    output logic                             o_hit,
    output logic                             o_miss,
    output logic                             o_eviction,
    output logic                             o_extra_hit,
    output logic [sactk_pkg::TOTAL_W-1:0]    o_total_hits,
    output logic [sactk_pkg::TOTAL_W-1:0]    o_total_misses,
    output logic [sactk_pkg::TOTAL_W-1:0]    o_total_evictions
);
    import sactk_pkg::*;

    `include "set_assoc_lru_cache_tracker_assert.svh"

    localparam int REQ_W = ADDR_W + MAX_SET_BITS + $clog2(MAX_WAYS + 1) + 1;

    logic             w_push;
    logic [REQ_W-1:0] w_req;
    logic             w_q_full;
    logic             w_q_valid;
    logic [REQ_W-1:0] w_q_data;
    logic             w_q_pop;
    logic             w_clearing;

    // front: config and address split
    sactk_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .REQ_W        (REQ_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_action    (i_action),
        .i_address   (i_address),
        .busy        (busy),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_q_full    (w_q_full),
        .i_clearing  (w_clearing),
        .o_push      (w_push),
        .o_req       (w_req)
    );

    // request queue
    sactk_queue #(
        .DATA_W (REQ_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_req),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // back: store update and totals
    sactk_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .AGE_WIDTH    (AGE_WIDTH),
        .REQ_W        (REQ_W)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (w_q_valid),
        .i_q_data          (w_q_data),
        .o_q_pop           (w_q_pop),
        .o_clearing        (w_clearing),
        .o_valid           (o_valid),
        .o_hit             (o_hit),
        .o_miss            (o_miss),
        .o_eviction        (o_eviction),
        .o_extra_hit       (o_extra_hit),
        .o_total_hits      (o_total_hits),
        .o_total_misses    (o_total_misses),
        .o_total_evictions (o_total_evictions)
    );

    // checks
    `SACTK_ASSERT_NXT(a_result_spacing, i_clk, i_rst_n, o_valid, !o_valid, "results back to back")
    `SACTK_ASSERT_IMP(a_quiet_in_clear, i_clk, i_rst_n, w_clearing, !o_valid && busy, "sweep not quiet")
    `SACTK_ASSERT_IMP(a_hit_or_miss, i_clk, i_rst_n, o_valid, o_hit ^ o_miss, "not one of hit and miss")
    `SACTK_ASSERT_IMP(a_evict_on_miss, i_clk, i_rst_n, o_valid && o_eviction, o_miss, "evict without miss")

endmodule
